>>> hw/rtl/fntf_pkg.sv
package fntf_pkg;

  localparam int MAX_NODES_DEF  = 8;
  localparam int COORD_BITS_DEF = 24;
  localparam int CW             = 24;
  localparam int SUM_W          = 29;
  localparam int FRAC_T         = 30;

  localparam logic [1:0] KIND_CENTROID = 2'd0;
  localparam logic [1:0] KIND_NORMAL   = 2'd1;
  localparam logic [1:0] KIND_TANGENT  = 2'd2;
  localparam logic [1:0] KIND_BINORMAL = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FEW      = 2'd1;
  localparam logic [1:0] ST_MANY     = 2'd2;
  localparam logic [1:0] ST_ZERO_DEN = 2'd3;

  typedef enum logic [2:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } op_t;

  typedef struct packed {
    logic       start;
    op_t        op;
    logic [63:0] a;
    logic [63:0] b;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
  } alu_rsp_t;

endpackage

>>> hw/rtl/face_normal_tangent_frame.sv
// face_normal_tangent_frame
// sequencing: nodes are accepted while in_tready is high; after a last node of a good face the
// first result word is valid after three centroid divides, two squares, a root, two tangent
// divides and the binormal steps; a zero normal ends after the centroid divides and normal
// selection, and a face with too few or too many nodes goes straight to output
// throughput: nodes back to back while in_tready is high; in_tready stays low until the final
// word of a face is taken
// reset: synchronous active-low rst_n clears count, sums, out_tvalid and the sequencer
module face_normal_tangent_frame #(
  parameter int MAX_NODES  = fntf_pkg::MAX_NODES_DEF,
  parameter int COORD_BITS = fntf_pkg::COORD_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [71:0]  in_tdata,   // node_x, node_y, node_z
  input  logic         in_tlast,   // last_node
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [191:0] out_tdata,  // comp_x, comp_y, comp_z
  output logic [3:0]   out_tuser,  // vector_kind, status
  output logic         out_tlast   // last_of_run
);

  localparam int CWL = (COORD_BITS < 24) ? COORD_BITS : 24;
  localparam int CNT_W = $clog2(MAX_NODES + 2);

  typedef enum logic [4:0] {
    S_IN, S_CDIV, S_CDIVW, S_VEC, S_NRM, S_SEL, S_SQA, S_SQAW, S_SQB, S_SQBW,
    S_SQRT, S_SQRTW, S_TDA, S_TDAW, S_TDB, S_TDBW, S_BIN, S_BINW, S_OUT
  } state_t;

  state_t state_r;
  logic [CNT_W-1:0] cnt_r;
  logic signed [28:0] sum_r [3];
  logic signed [23:0] cor_r [4][3];
  logic [1:0] idx_r;
  logic signed [63:0] cen_r [3];
  logic signed [63:0] a_r [3];
  logic signed [63:0] t_r [3];
  logic signed [63:0] b_r [3];
  logic [1:0] i1_r;
  logic [31:0] u1_r, u3_r;
  logic [63:0] sq_r, d_r;
  logic [3:0] bstep_r;
  logic signed [127:0] bacc_r;
  logic [1:0] ocnt_r;
  logic [1:0] ost_r;

  fntf_pkg::alu_req_t req;
  fntf_pkg::alu_rsp_t rsp;

  fntf_alu u_alu (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

  logic signed [23:0] nx [3];
  logic signed [25:0] v1 [3], v2 [3], v3 [3];
  logic signed [63:0] nsum [3];
  logic [63:0] m [3];
  logic [1:0] i1c, i3;
  logic [63:0] u1w, u3w;
  logic [5:0] sh;
  logic [63:0] sq_sum;
  logic signed [63:0] dnum;
  logic [63:0] dmag;
  logic [63:0] qsig;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nx[k] = 24'(signed'(in_tdata[k*24 +: CWL]));
    end
    for (int k = 0; k < 3; k++) begin
      v1[k] = 26'(cor_r[1][k]) - 26'(cor_r[0][k]);
      v2[k] = 26'(cor_r[2][k]) - 26'(cor_r[0][k]);
      v3[k] = 26'(cor_r[3][k]) - 26'(cor_r[0][k]);
    end
    for (int k = 0; k < 3; k++) begin
      nsum[k] = v1[(k+1)%3] * v2[(k+2)%3] - v1[(k+2)%3] * v2[(k+1)%3]
              + v2[(k+1)%3] * v3[(k+2)%3] - v2[(k+2)%3] * v3[(k+1)%3];
    end
    for (int k = 0; k < 3; k++) begin
      m[k] = a_r[k][63] ? 64'(-a_r[k]) : 64'(a_r[k]);
    end
    i1c = 2'd0;
    if (m[1] > m[0]) i1c = 2'd1;
    if (m[2] > m[i1c]) i1c = 2'd2;
    i3  = (i1_r == 2'd0) ? 2'd2 : i1_r - 2'd1;
    sh = '0;
    for (int k = 0; k < 34; k++) begin
      if ((m[i1_r] >> k) >= (64'd1 << 30) && (m[i1_r] >> (k+1)) < (64'd1 << 30))
        sh = 6'(k + 1);
    end
    u1w = m[i1_r] >> sh;
    u3w = m[i3] >> sh;
    sq_sum = sq_r + rsp.res;
    dnum = (idx_r == 2'd0) ? 64'(sum_r[0]) : (idx_r == 2'd1) ? 64'(sum_r[1]) : 64'(sum_r[2]);
    dmag = dnum[63] ? 64'(-dnum) : 64'(dnum);
    qsig = rsp.res;
  end

  // binormal: component k via 4 partial products: two signed 64x32 products, each split into 32-bit halves
  logic signed [63:0] bp;
  logic signed [31:0] bq;
  logic signed [127:0] bprod;
  always_comb begin
    logic [1:0] kk;
    logic [1:0] pi, qi;
    logic sel;
    kk  = 2'(bstep_r[3:2]);
    sel = bstep_r[1];
    pi  = (kk == 2'd0) ? 2'd1 : (kk == 2'd1) ? 2'd2 : 2'd0;
    qi  = (kk == 2'd0) ? 2'd2 : (kk == 2'd1) ? 2'd0 : 2'd1;
    bp  = sel ? a_r[qi] : a_r[pi];
    bq  = sel ? t_r[pi][31:0] : t_r[qi][31:0];
    bprod = bstep_r[0] ? 128'(signed'(bp[63:32])) * 128'(bq) * 128'sd4294967296
                       : 128'(signed'({1'b0, bp[31:0]})) * 128'(bq);
  end

  always_comb begin
    req = '0;
    case (state_r)
      S_CDIV: begin req.start = 1'b1; req.op = fntf_pkg::OP_DIV;
        req.a = dmag; req.b = 64'(cnt_r); end
      S_SQA: begin req.start = 1'b1; req.op = fntf_pkg::OP_MUL;
        req.a = 64'(u1_r); req.b = 64'(u1_r); end
      S_SQB: begin req.start = 1'b1; req.op = fntf_pkg::OP_MUL;
        req.a = 64'(u3_r); req.b = 64'(u3_r); end
      S_SQRT: begin req.start = 1'b1; req.op = fntf_pkg::OP_SQRT; req.a = sq_r; end
      S_TDA: begin req.start = 1'b1; req.op = fntf_pkg::OP_DIV;
        req.a = 64'(u3_r) << 30; req.b = d_r; end
      S_TDB: begin req.start = 1'b1; req.op = fntf_pkg::OP_DIV;
        req.a = 64'(u1_r) << 30; req.b = d_r; end
      default: req = '0;
    endcase
  end

  assign in_tready = (state_r == S_IN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IN;
      cnt_r   <= '0;
      for (int k = 0; k < 3; k++) sum_r[k] <= '0;
      out_tvalid <= 1'b0;
    end else begin
      case (state_r)
        S_IN: begin
          if (in_tvalid) begin
            if (32'(cnt_r) <= MAX_NODES) begin
              if (32'(cnt_r) < 4)
                for (int k = 0; k < 3; k++) cor_r[cnt_r[1:0]][k] <= nx[k];
              if (32'(cnt_r) < MAX_NODES)
                for (int k = 0; k < 3; k++) sum_r[k] <= sum_r[k] + 29'(nx[k]);
              cnt_r <= cnt_r + 1'b1;
            end
            if (in_tlast) begin
              ocnt_r <= 2'd0;
              if (32'(cnt_r) < 3) begin
                ost_r <= fntf_pkg::ST_FEW; state_r <= S_OUT; out_tvalid <= 1'b1;
              end else if (32'(cnt_r) >= MAX_NODES) begin
                ost_r <= fntf_pkg::ST_MANY; state_r <= S_OUT; out_tvalid <= 1'b1;
              end else begin
                ost_r <= fntf_pkg::ST_OK; idx_r <= 2'd0; state_r <= S_CDIV;
              end
            end
          end
        end
        S_CDIV: state_r <= S_CDIVW;
        S_CDIVW: if (rsp.done) begin
          cen_r[idx_r] <= dnum[63] ? 64'(-qsig) : qsig;
          if (idx_r == 2'd2) state_r <= S_VEC;
          else begin idx_r <= idx_r + 2'd1; state_r <= S_CDIV; end
        end
        S_VEC: begin
          for (int k = 0; k < 3; k++) a_r[k] <= nsum[k] >>> 1;
          state_r <= S_SEL;
        end
        S_SEL: begin
          i1_r <= i1c;
          if (m[i1c] == 64'd0) begin
            ost_r <= fntf_pkg::ST_ZERO_DEN; state_r <= S_OUT; out_tvalid <= 1'b1;
          end else state_r <= S_NRM;
        end
        S_NRM: begin
          u1_r <= u1w[31:0]; u3_r <= u3w[31:0]; state_r <= S_SQA;
        end
        S_SQA: state_r <= S_SQAW;
        S_SQAW: if (rsp.done) begin sq_r <= rsp.res; state_r <= S_SQB; end
        S_SQB: state_r <= S_SQBW;
        S_SQBW: if (rsp.done) begin sq_r <= sq_sum; state_r <= S_SQRT; end
        S_SQRT: state_r <= S_SQRTW;
        S_SQRTW: if (rsp.done) begin d_r <= rsp.res; state_r <= S_TDA; end
        S_TDA: state_r <= S_TDAW;
        S_TDAW: if (rsp.done) begin
          t_r[i1_r] <= a_r[i3][63] ? 64'(-qsig) : qsig;
          t_r[(i1_r == 2'd2) ? 2'd0 : i1_r + 2'd1] <= '0;
          state_r <= S_TDB;
        end
        S_TDB: state_r <= S_TDBW;
        S_TDBW: if (rsp.done) begin
          t_r[i3] <= (a_r[i1_r] > 0) ? 64'(-qsig) : qsig;
          bstep_r <= '0; bacc_r <= '0;
          state_r <= S_BIN;
        end
        S_BIN: begin
          bacc_r <= bstep_r[1] ? bacc_r - bprod : bacc_r + bprod;
          bstep_r <= bstep_r + 4'd1;
          if (bstep_r[1:0] == 2'd3) state_r <= S_BINW;
        end
        S_BINW: begin
          b_r[bstep_r[3:2] - 2'd1] <= 64'(bacc_r >>> 30);
          bacc_r <= '0;
          if (bstep_r == 4'd12) begin
            state_r <= S_OUT; out_tvalid <= 1'b1;
          end else state_r <= S_BIN;
        end
        S_OUT: if (out_tready) begin
          if (out_tlast) begin
            out_tvalid <= 1'b0; state_r <= S_IN; cnt_r <= '0;
            for (int k = 0; k < 3; k++) sum_r[k] <= '0;
          end else ocnt_r <= ocnt_r + 2'd1;
        end
        default: state_r <= S_IN;
      endcase
    end
  end

  always_comb begin
    out_tdata = '0;
    out_tuser = {ost_r, ocnt_r};
    out_tlast = (ost_r != fntf_pkg::ST_OK) || (ocnt_r == 2'd3);
    if (ost_r == fntf_pkg::ST_OK) begin
      case (ocnt_r)
        fntf_pkg::KIND_CENTROID: out_tdata = {cen_r[2], cen_r[1], cen_r[0]};
        fntf_pkg::KIND_NORMAL:   out_tdata = {a_r[2], a_r[1], a_r[0]};
        fntf_pkg::KIND_TANGENT:  out_tdata = {t_r[2], t_r[1], t_r[0]};
        default:                 out_tdata = {b_r[2], b_r[1], b_r[0]};
      endcase
    end
  end

endmodule

>>> hw/rtl/fntf_alu.sv
module fntf_alu (
  input  logic               clk,
  input  logic               rst_n,
  input  fntf_pkg::alu_req_t req,
  output fntf_pkg::alu_rsp_t rsp
);

  // unsigned shared unit: registered 32x32 multiply, 64/64 restoring divide
  // and 64-bit integer square root, one bit per cycle
  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_SQRT,
    S_DONE
  } state_t;

  state_t      state_r;
  logic [6:0]  cnt_r;
  logic [63:0] acc_r;
  logic [63:0] rem_r;
  logic [63:0] den_r;
  logic [63:0] root_r;
  logic [63:0] res_r;

  logic [64:0] rem_sh;
  logic [64:0] trial;
  logic [63:0] sq_bit;
  logic [63:0] sq_try;
  logic [63:0] mul_p;

  always_comb begin
    mul_p  = {32'd0, req.a[31:0]} * {32'd0, req.b[31:0]};
    rem_sh = {rem_r, acc_r[63]};
    trial  = rem_sh - {1'b0, den_r};
    sq_bit = 64'd1 << {cnt_r[5:0], 1'b0};
    sq_try = root_r + sq_bit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (req.start) begin
            case (req.op)
              fntf_pkg::OP_MUL: begin
                res_r   <= mul_p;
                state_r <= S_DONE;
              end
              fntf_pkg::OP_DIV: begin
                acc_r   <= req.a;
                den_r   <= req.b;
                rem_r   <= '0;
                cnt_r   <= 7'd64;
                state_r <= S_DIV;
              end
              fntf_pkg::OP_SQRT: begin
                acc_r   <= req.a;
                root_r  <= '0;
                cnt_r   <= 7'd31;
                state_r <= S_SQRT;
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_DIV: begin
          if (!trial[64]) begin
            rem_r <= trial[63:0];
            acc_r <= {acc_r[62:0], 1'b1};
          end else begin
            rem_r <= rem_sh[63:0];
            acc_r <= {acc_r[62:0], 1'b0};
          end
          cnt_r <= cnt_r - 7'd1;
          if (cnt_r == 7'd1) begin
            state_r <= S_DONE;
            res_r   <= !trial[64] ? {acc_r[62:0], 1'b1} : {acc_r[62:0], 1'b0};
          end
        end
        S_SQRT: begin
          if (acc_r >= sq_try) begin
            acc_r  <= acc_r - sq_try;
            root_r <= (root_r >> 1) + sq_bit;
          end else begin
            root_r <= root_r >> 1;
          end
          cnt_r <= cnt_r - 7'd1;
          if (cnt_r == 7'd0) begin
            state_r <= S_DONE;
            res_r   <= (acc_r >= sq_try) ? (root_r >> 1) + sq_bit : root_r >> 1;
          end
        end
        S_DONE: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign rsp.done = (state_r == S_DONE);
  assign rsp.res  = res_r;

endmodule
